// ----- rtl/postfix_stack_calculator_top_macros.svh -----
// Assertion macros shared by the postfix stack calculator RTL.
// Expect a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef POSTFIX_STACK_CALCULATOR_TOP_MACROS_SVH
`define POSTFIX_STACK_CALCULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psc_pkg.sv -----
// Package for the postfix stack calculator: sizes, opcodes, status codes and
// the command/status structs between controller and datapath. No dependencies.
package psc_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 10;
  localparam int OP_W        = 3;
  localparam int ST_W        = 3;
  localparam int TDATA_W     = 48;

  localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OP_W-1:0] OP_POP      = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK_TOP = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK_BOT = 3'd3;
  localparam logic [OP_W-1:0] OP_ADD      = 3'd4;
  localparam logic [OP_W-1:0] OP_SUB      = 3'd5;
  localparam logic [OP_W-1:0] OP_MUL      = 3'd6;
  localparam logic [OP_W-1:0] OP_DIV      = 3'd7;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd3;
  localparam logic [ST_W-1:0] ST_FEW   = 3'd4;
  localparam logic [ST_W-1:0] ST_DIV0  = 3'd5;

  typedef struct packed {
    logic load;       // capture the accepted item
    logic set_err;    // record the decode error code
    logic set_div0;   // record divide by zero
    logic push_wr;    // write push value at top, count up
    logic rd;         // issue a stack read
    logic rd_second;  // arithmetic: read the left operand
    logic pop1;       // count down by one
    logic pop2;       // count down by two
    logic cap_res_rd; // result from read data
    logic cap_b;      // right operand from read data
    logic cap_a;      // left operand from read data
    logic alu;        // result from add/sub/mul
    logic div_start;  // launch the divider
    logic div_cap;    // result from divider
    logic res_wr;     // write result over the operands, count down by one
    logic finish;     // load the output register
  } cmd_t;

  typedef struct packed {
    logic err;
    logic is_push;
    logic is_pop;
    logic is_arith;
    logic is_div;
    logic b_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/psc_div.sv -----
// Restoring divider for the postfix stack calculator, one quotient bit a cycle.
// Unsigned magnitudes in, quotient and remainder-is-zero flag out. Uses psc_pkg.
module psc_div import psc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient,
  output logic              rem_zero
);

  localparam int STEP_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DATA_W:0]   trial;

  assign trial = {rem, quo[DATA_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (step == STEP_W'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
  assign rem_zero = (rem == '0);

endmodule

// ----- rtl/psc_dp.sv -----
// Datapath of the postfix stack calculator: stack memory, count, operands, ALU,
// divider and output register. Uses psc_pkg, psc_div and the assertion macros.
`include "postfix_stack_calculator_top_macros.svh"

module psc_dp import psc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [TDATA_W-1:0] s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [OP_W-1:0]   op;
  logic [DATA_W-1:0] val;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] res;
  logic [ST_W-1:0]   st;

  logic [ST_W-1:0]   err_code;
  logic [CNT_W-1:0]  rd_full;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic              div_rz;
  logic [DATA_W-1:0] div_res;

  // Decode-time error check on the captured item.
  always_comb begin
    err_code = ST_OK;
    case (op)
      OP_PUSH: begin
        if (count >= CNT_W'(STACK_DEPTH)) err_code = ST_FULL;
      end
      OP_POP, OP_PEEK_TOP, OP_PEEK_BOT: begin
        if (count == '0) err_code = ST_EMPTY;
        else if (op != OP_POP && CNT_W'(idx) >= count) err_code = ST_RANGE;
      end
      default: begin
        if (count < CNT_W'(2)) err_code = ST_FEW;
      end
    endcase
  end

  always_comb begin
    case (op)
      OP_POP:      rd_full = count - CNT_W'(1);
      OP_PEEK_TOP: rd_full = count - CNT_W'(1) - CNT_W'(idx);
      OP_PEEK_BOT: rd_full = CNT_W'(idx);
      default:     rd_full = cmd.rd_second ? count - CNT_W'(2) : count - CNT_W'(1);
    endcase
  end
  assign rd_addr = rd_full[ADDR_W-1:0];

  assign wr_en   = cmd.push_wr || cmd.res_wr;
  assign wr_addr = cmd.push_wr ? count[ADDR_W-1:0] : ADDR_W'(count - CNT_W'(2));
  assign wr_data = cmd.push_wr ? val : res;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data <= mem[rd_addr];
  end

  always_comb begin
    case (op)
      OP_ADD:  alu_res = a + b;
      OP_SUB:  alu_res = a - b;
      OP_MUL:  alu_res = a * b;
      default: alu_res = res;
    endcase
  end

  assign mag_a = a[DATA_W-1] ? DATA_W'(0) - a : a;
  assign mag_b = b[DATA_W-1] ? DATA_W'(0) - b : b;

  psc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (div_q),
    .rem_zero (div_rz)
  );

  // Exact: negate on sign mismatch; inexact: floor, i.e. one's complement.
  always_comb begin
    if (a[DATA_W-1] ^ b[DATA_W-1]) div_res = div_rz ? DATA_W'(0) - div_q : ~div_q;
    else                           div_res = div_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= s_tdata[OP_W-1:0];
      val <= s_tdata[OP_W +: DATA_W];
      idx <= s_tdata[OP_W + DATA_W +: IDX_W];
      res <= '0;
    end else if (cmd.cap_res_rd) begin
      res <= rd_data;
    end else if (cmd.alu) begin
      res <= alu_res;
    end else if (cmd.div_cap) begin
      res <= div_res;
    end
    if (cmd.cap_b) b <= rd_data;
    if (cmd.cap_a) a <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      st    <= ST_OK;
    end else begin
      if (cmd.load)          st <= ST_OK;
      else if (cmd.set_err)  st <= err_code;
      else if (cmd.set_div0) st <= ST_DIV0;
      if (cmd.push_wr)     count <= count + CNT_W'(1);
      else if (cmd.pop1)   count <= count - CNT_W'(1);
      else if (cmd.pop2)   count <= count - CNT_W'(2);
      else if (cmd.res_wr) count <= count - CNT_W'(1);
    end
  end

  // Output register: hold the item until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {(TDATA_W - DATA_W - ST_W - CNT_W)'(0), count, st, res};
    end
  end

  assign sts.err      = (err_code != ST_OK);
  assign sts.is_push  = (op == OP_PUSH);
  assign sts.is_pop   = (op == OP_POP);
  assign sts.is_arith = op[2];
  assign sts.is_div   = (op == OP_DIV);
  assign sts.b_zero   = (b == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = !m_tvalid || m_tready;

  `PSC_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(STACK_DEPTH), "stack count above depth")
  `PSC_ASSERT_NXT(a_push_count, cmd.push_wr, count == $past(count) + CNT_W'(1), "push lost count")
  `PSC_ASSERT_IMP(a_err_zero, cmd.finish && st != ST_OK, res == '0, "error item with value")

endmodule

// ----- rtl/psc_ctrl.sv -----
// Controller of the postfix stack calculator: sequences decode, stack reads,
// ALU or divider, write-back and output load. Uses psc_pkg command/status types.
module psc_ctrl import psc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RDRES  = 4'd2;
  localparam logic [3:0] S_RDB    = 4'd3;
  localparam logic [3:0] S_RDA    = 4'd4;
  localparam logic [3:0] S_EXEC   = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.err) begin
          cmd.set_err = 1'b1;
          state_next  = S_FINISH;
        end else if (sts.is_push) begin
          cmd.push_wr = 1'b1;
          state_next  = S_FINISH;
        end else if (sts.is_arith) begin
          cmd.rd     = 1'b1;
          state_next = S_RDB;
        end else begin
          cmd.rd     = 1'b1;
          cmd.pop1   = sts.is_pop;
          state_next = S_RDRES;
        end
      end
      S_RDRES: begin
        cmd.cap_res_rd = 1'b1;
        state_next     = S_FINISH;
      end
      S_RDB: begin
        cmd.cap_b     = 1'b1;
        cmd.rd        = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = S_RDA;
      end
      S_RDA: begin
        cmd.cap_a  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.is_div) begin
          cmd.alu    = 1'b1;
          state_next = S_WRITE;
        end else if (sts.b_zero) begin
          cmd.set_div0 = 1'b1;
          cmd.pop2     = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_next  = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.res_wr = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ----- rtl/postfix_stack_calculator_top.sv -----
// Postfix stack calculator: a 1024-entry stack of 32-bit signed integers driven
// by one opcode per input item, with one result item per input item.
// Channels: slave side s_tvalid/s_tready/s_tdata takes an item holding opcode,
// push value and peek index; master side m_tvalid/m_tready/m_tdata returns the
// value, a status code and the stack depth left after the operation.
// The divide's run time is set by the restoring divider, one quotient bit a
// cycle over 32 bits; that of the other operations by the single read port of
// the stack memory.
// One item is worked on at a time; the next is taken once the current result
// sits in the output register, even while that result still waits to be taken.
// Reset (rst, synchronous) empties the stack and drops any pending result; the
// stack memory itself is not cleared, as entries above the depth are never read.
// When the receiver stalls, the result is held in the output register and the
// controller holds its finished item until the register frees up.
// Divide gives the exact quotient or, when inexact, the floored quotient; sums,
// differences and products wrap at 32 bits. Depends on psc_pkg, psc_ctrl, psc_dp.
module postfix_stack_calculator_top import psc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // [2:0] opcode, [34:3] push_value, [44:35] peek_index, [47:45] zero
  input  logic [TDATA_W-1:0] s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // [31:0] result_value, [34:32] status, [45:35] depth, [47:46] zero
  output logic [TDATA_W-1:0] m_tdata
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each item through decode, reads, compute and write-back.
  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the stack, operands and the output register.
  psc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- sim/tb_postfix_stack_calculator_top.sv -----
// Self-checking testbench for postfix_stack_calculator_top: drives opcode items on the
// input stream, predicts each result with a shadow stack and checks every returned item.
// Depends on psc_pkg and the postfix_stack_calculator_top RTL.
module tb_postfix_stack_calculator_top import psc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Ceiling on consecutive cycles with no item moving on either side. It lies well
  // above both the slowest item (divide plus both sides' longest gaps) and the long
  // receiver hold-off, so this allows ample margin.
  localparam int WATCHDOG_LIMIT = 4000;
  // Long receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_OFF_CYCLES = 400;
  // Cycles to idle after the last expected result, beyond the divide latency.
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS = 30;

  // One result item as it appears on the output stream.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         depth;
  } calc_result_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // [2:0] opcode, [34:3] push_value, [44:35] peek_index, [47:45] zero
  logic [TDATA_W-1:0] s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // [31:0] result_value, [34:32] status, [45:35] depth, [47:46] zero
  logic [TDATA_W-1:0] m_tdata;

  // Shadow copy of the stack, updated as each item is accepted.
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_depth = 0;

  // Results still owed by the block, oldest first.
  calc_result_t pending_results[$];

  int  fail_count        = 0;
  int  idle_cycles       = 0;
  // Gap control: when set, the side concerned offers or takes back to back.
  bit  tx_burst          = 1'b0;
  bit  rx_burst          = 1'b0;
  // Set by a test to make the receiver refuse items for this many cycles.
  int  ready_hold_cycles = 0;

  logic [OP_W-1:0] arith_ops [4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  postfix_stack_calculator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Work out the result of one opcode item against the shadow stack and advance it.
  // Arithmetic pops the top two entries; the earlier one is the left operand.
  function automatic calc_result_t compute_stack_result(input logic [OP_W-1:0] op,
                                                        input logic [DATA_W-1:0] push_val,
                                                        input logic [IDX_W-1:0] idx);
    calc_result_t             res;
    logic signed [DATA_W-1:0] lhs;
    logic signed [DATA_W-1:0] rhs;
    longint                   quot;
    res.value  = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_stack[shadow_depth] = push_val;
          shadow_depth++;
        end
      end
      OP_POP, OP_PEEK_TOP, OP_PEEK_BOT: begin
        if (shadow_depth == 0) begin
          res.status = ST_EMPTY;
        end else if (op == OP_POP) begin
          shadow_depth--;
          res.value = shadow_stack[shadow_depth];
        end else if (idx >= shadow_depth) begin
          res.status = ST_RANGE;
        end else if (op == OP_PEEK_TOP) begin
          res.value = shadow_stack[shadow_depth - 1 - idx];
        end else begin
          res.value = shadow_stack[idx];
        end
      end
      default: begin
        if (shadow_depth < 2) begin
          res.status = ST_FEW;
        end else begin
          rhs = shadow_stack[shadow_depth - 1];
          lhs = shadow_stack[shadow_depth - 2];
          shadow_depth -= 2;
          case (op)
            OP_ADD: res.value = lhs + rhs;
            OP_SUB: res.value = lhs - rhs;
            OP_MUL: res.value = lhs * rhs;
            default: begin
              if (rhs == 0) begin
                res.status = ST_DIV0;
              end else begin
                // Truncate, then step down to the floor when inexact and the
                // signs differ; the most negative value over minus one wraps.
                quot = longint'(lhs) / longint'(rhs);
                if ((longint'(lhs) % longint'(rhs) != 0) && ((lhs < 0) != (rhs < 0)))
                  quot = quot - 1;
                res.value = quot[DATA_W-1:0];
              end
            end
          endcase
          if (res.status == ST_OK) begin
            shadow_stack[shadow_depth] = res.value;
            shadow_depth++;
          end
        end
      end
    endcase
    res.depth = shadow_depth[CNT_W-1:0];
    return res;
  endfunction

  // Offer one item after a random gap, hold it until taken, then log its prediction.
  // tvalid is only lowered when a gap follows, so a back-to-back item keeps it high.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] push_val,
                           input logic [IDX_W-1:0] idx);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, idx, push_val, op};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(compute_stack_result(op, push_val, idx));
  endtask

  // Favour small values (exact and inexact divides, zero divisors) and the extremes.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] corner [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1};
    case ($urandom_range(0, 7))
      0, 1, 2: return DATA_W'($signed($urandom_range(0, 40)) - 20);
      3:       return corner[$urandom_range(0, 4)];
      default: return $urandom;
    endcase
  endfunction

  // Mostly a valid peek position, sometimes anywhere in the index range.
  function automatic logic [IDX_W-1:0] pick_index();
    if (shadow_depth > 0 && $urandom_range(0, 4) != 0)
      return IDX_W'($urandom_range(0, shadow_depth - 1));
    return IDX_W'($urandom_range(0, 1023));
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare every taken result with the oldest prediction, field by field.
  always @(posedge clk) begin
    calc_result_t got;
    calc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.value  = m_tdata[31:0];
      got.status = m_tdata[34:32];
      got.depth  = m_tdata[45:35];
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: result with none expected, expected none, actual %0d/%0d/%0d",
                   $time, got.value, got.status, got.depth);
      end else begin
        want = pending_results.pop_front();
        if ($isunknown(m_tdata[45:0])) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t ns: unknown bits in result, expected %0d/%0d/%0d, actual %h",
                     $time, want.value, want.status, want.depth, m_tdata);
        end else begin
          check_field("result_value", want.value, got.value);
          check_field("status", want.status, got.status);
          check_field("depth", want.depth, got.depth);
        end
      end
    end
  end

  // Receiver: a random stall before each item, or a long hold-off when a test asks.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (ready_hold_cycles > 0) begin
        stall = ready_hold_cycles;
        ready_hold_cycles = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired with %0d results outstanding", $time,
               pending_results.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Empty-stack and too-few-operand errors, range errors, wrap on add and on the most
  // negative value over minus one, exact and floored divides, divide by zero, product
  // wrap, and peeks at both ends.
  task automatic test_directed_edges();
    send_item(OP_POP, 32'h0, 10'd0);
    send_item(OP_PEEK_TOP, 32'hFFFF_FFFF, 10'd0);
    send_item(OP_PEEK_BOT, 32'h0, 10'd1023);
    send_item(OP_ADD, 32'h0, 10'd0);
    send_item(OP_PUSH, 32'h7FFF_FFFF, 10'd0);
    send_item(OP_DIV, 32'h0, 10'd0);
    send_item(OP_PEEK_TOP, 32'h0, 10'd1);
    send_item(OP_PUSH, 32'h1, 10'd0);
    send_item(OP_ADD, 32'h0, 10'd0);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 10'd0);
    send_item(OP_DIV, 32'h0, 10'd0);
    send_item(OP_PUSH, -32'sd7, 10'd0);
    send_item(OP_PUSH, 32'd2, 10'd0);
    send_item(OP_DIV, 32'h0, 10'd0);
    send_item(OP_MUL, 32'h0, 10'd0);
    send_item(OP_PUSH, 32'd6, 10'd0);
    send_item(OP_PUSH, 32'h0, 10'd0);
    send_item(OP_DIV, 32'h0, 10'd0);
    send_item(OP_PUSH, -32'sd8, 10'd0);
    send_item(OP_PUSH, 32'd2, 10'd0);
    send_item(OP_DIV, 32'h0, 10'd0);
    send_item(OP_PEEK_BOT, 32'h0, 10'd0);
    send_item(OP_PEEK_TOP, 32'h0, 10'd1);
    send_item(OP_PEEK_BOT, 32'h0, 10'd2);
    send_item(OP_SUB, 32'h0, 10'd0);
    send_item(OP_POP, 32'h0, 10'd0);
  endtask

  // Random mix at shallow depth: mostly sensible opcodes, some pure noise items.
  task automatic test_random_mix(input int n_items);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_item(OP_PUSH, pick_value(), IDX_W'($urandom));
      else if (pick < 45)
        send_item(OP_POP, $urandom, IDX_W'($urandom));
      else if (pick < 55)
        send_item(OP_PEEK_TOP, $urandom, pick_index());
      else if (pick < 62)
        send_item(OP_PEEK_BOT, $urandom, pick_index());
      else if (pick < 90)
        send_item(arith_ops[$urandom_range(0, 3)], $urandom, IDX_W'($urandom));
      else
        send_item(OP_W'($urandom), pick_value(), IDX_W'($urandom));
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Hold the receiver off while the sender keeps offering back to back, so the
  // output register and the controller fill and the input stalls.
  task automatic test_output_backpressure();
    tx_burst = 1'b1;
    ready_hold_cycles = HOLD_OFF_CYCLES;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2)
        send_item(arith_ops[$urandom_range(0, 3)], $urandom, IDX_W'($urandom));
      else
        send_item(OP_PUSH, pick_value(), IDX_W'($urandom));
    end
    tx_burst = 1'b0;
  endtask

  // Grow the stack to its capacity with some peeks and arithmetic mixed in, then
  // exercise push when full and peeks at the deepest indexes.
  task automatic test_fill_to_capacity();
    int pick;
    int count;
    count = 0;
    while (shadow_depth < STACK_DEPTH) begin
      if (count % 60 == 0) begin
        tx_burst = ($urandom_range(0, 2) == 0);
        rx_burst = ($urandom_range(0, 2) == 0);
      end
      count++;
      pick = $urandom_range(0, 99);
      if (pick < 85)
        send_item(OP_PUSH, pick_value(), IDX_W'($urandom));
      else if (pick < 90)
        send_item(($urandom_range(0, 1) != 0) ? OP_PEEK_TOP : OP_PEEK_BOT, $urandom,
                  pick_index());
      else if (pick < 97)
        send_item(arith_ops[$urandom_range(0, 3)], $urandom, IDX_W'($urandom));
      else
        send_item(OP_POP, $urandom, IDX_W'($urandom));
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    send_item(OP_PUSH, 32'h1234_5678, 10'd0);
    send_item(OP_PUSH, 32'h8000_0000, 10'd1023);
    send_item(OP_PEEK_TOP, 32'h0, 10'd1023);
    send_item(OP_PEEK_BOT, 32'h0, 10'd1023);
    send_item(OP_PEEK_TOP, 32'h0, 10'd0);
    send_item(OP_POP, 32'h0, 10'd0);
    send_item(OP_PEEK_BOT, 32'h0, 10'd1023);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 10'd0);
    send_item(OP_PUSH, 32'h0, 10'd0);
    send_item(OP_MUL, 32'h0, 10'd0);
    send_item(OP_PEEK_BOT, 32'h0, 10'd1022);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_random_mix(150);
    test_output_backpressure();
    test_fill_to_capacity();

    // Drop valid, wait for every owed result, then idle past the divide latency.
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_div.sv
rtl/psc_dp.sv
rtl/psc_ctrl.sv
rtl/postfix_stack_calculator_top.sv
sim/tb_postfix_stack_calculator_top.sv
